// File: rtl/duty_cycle_serial_receiver_top_macros.svh
// Assertion macros shared by the duty-cycle serial receiver RTL.
`ifndef DUTY_CYCLE_SERIAL_RECEIVER_TOP_MACROS_SVH
`define DUTY_CYCLE_SERIAL_RECEIVER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DCSR_ASSERT_IMPL(label, clock, rstn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DCSR_ASSERT_NEXT(label, clock, rstn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/dcsr_pkg.sv
// Types and constants of the duty-cycle serial receiver.
`default_nettype none

package dcsr_pkg;

    // Pulse position within a byte and byte position within a packet.
    localparam int POS_W = 4;
    localparam int IDX_W = 2;
    localparam int CNT_W = 2;

    localparam logic [POS_W-1:0] POS_START = 4'd0;
    localparam logic [POS_W-1:0] POS_FIRST_DATA = 4'd1;
    localparam logic [POS_W-1:0] POS_PARITY = 4'd9;

    localparam logic [CNT_W-1:0] BYTES_RESET = 2'd3;
    localparam logic [IDX_W-1:0] IDX_INVALID = 2'd3;

    // Classification thresholds in percent of the bit window.
    localparam int PCT_SCALE = 100;
    localparam int PCT_SHORT = 11;
    localparam int PCT_ONE = 36;
    localparam int PCT_AMB = 61;

    // Decoded bit of one pulse with its class marks.
    typedef struct packed {
        logic bit_val;
        logic is_short;
        logic is_long;
        logic is_amb;
    } pulse_class_t;

    // Class marks collected over one byte.
    typedef struct packed {
        logic short_seen;
        logic long_seen;
        logic amb_seen;
    } class_flags_t;

endpackage

`default_nettype wire

// File: rtl/dcsr_classify.sv
// Classifies one pulse low time against the bit window.
`default_nettype none

module dcsr_classify
    import dcsr_pkg::*;
#(
    parameter int TIME_BITS = 16
) (
    input  wire logic [TIME_BITS-1:0] low_time,
    input  wire logic [TIME_BITS:0]   window,
    output pulse_class_t              cls
);

    // Products of up to 100 times the time need seven extra bits.
    localparam int CW = TIME_BITS + 7;

    logic [CW-1:0] scaled_t;
    logic [CW-1:0] lim_short;
    logic [CW-1:0] lim_one;
    logic [CW-1:0] lim_amb;
    logic          at_short;
    logic          at_one;
    logic          at_amb;
    logic          over;

    // Constant multiplies of the time and of the window.
    assign scaled_t  = CW'(low_time) * CW'(PCT_SCALE);
    assign lim_short = CW'(window) * CW'(PCT_SHORT);
    assign lim_one   = CW'(window) * CW'(PCT_ONE);
    assign lim_amb   = CW'(window) * CW'(PCT_AMB);

    // Each band is bounded above, inclusive.
    assign at_short = scaled_t <= lim_short;
    assign at_one   = scaled_t <= lim_one;
    assign at_amb   = scaled_t <= lim_amb;
    assign over     = {1'b0, low_time} > window;

    // Ambiguous, short and long pulses decode as zero.
    always_comb
    begin
        cls.is_short = at_short;
        cls.bit_val  = at_one && !at_short;
        cls.is_amb   = at_amb && !at_one;
        cls.is_long  = !at_amb && over;
    end

endmodule

`default_nettype wire

// File: rtl/dcsr_core.sv
// Pulse sequencing, byte assembly and the result register.
`default_nettype none

module dcsr_core
    import dcsr_pkg::*;
#(
    parameter int TIME_BITS = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    input  wire logic [TIME_BITS-1:0] item_time,
    input  wire logic                 item_new_packet,
    input  wire logic [CNT_W-1:0]     bytes_cfg,
    output logic                      advance,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [7:0]                data_byte,
    output logic                      parity_error,
    output logic                      short_seen,
    output logic                      long_seen,
    output logic                      ambiguous_seen,
    output logic [IDX_W-1:0]          byte_index,
    output logic                      last
);

    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [TIME_BITS:0]   window_reg, window_next;
    logic [8:0]           shift_reg, shift_next;
    class_flags_t         flags_reg, flags_next;
    logic                 out_valid_reg;

    logic [7:0]           data_reg;
    logic                 par_err_reg;
    class_flags_t         oflags_reg;
    logic [IDX_W-1:0]     oidx_reg;
    logic                 last_reg;

    logic [POS_W-1:0]     pos_eff;
    logic [IDX_W-1:0]     idx_eff;
    logic                 first_start;
    logic                 emit;
    logic                 fin;
    logic [CNT_W-1:0]     n_bytes;
    logic [IDX_W:0]       idx_plus;
    pulse_class_t         cls;

    dcsr_classify #(
        .TIME_BITS (TIME_BITS)
    ) u_classify (
        .low_time (item_time),
        .window   (window_reg),
        .cls      (cls)
    );

    // A new-packet mark restarts the pulse count at the first start pulse.
    assign pos_eff     = item_new_packet ? POS_START : pos_reg;
    assign idx_eff     = item_new_packet ? '0 : idx_reg;
    assign first_start = (pos_eff == POS_START) && (idx_eff == '0);
    assign emit        = (pos_eff == POS_PARITY);

    // A zero byte count acts as one.
    assign n_bytes  = (bytes_cfg == '0) ? CNT_W'(1) : bytes_cfg;
    assign idx_plus = {1'b0, idx_eff} + (IDX_W+1)'(1);
    assign fin      = idx_plus >= (IDX_W+1)'(n_bytes);

    // The word moves on unless it yields a byte that finds the result register full and not being read.
    assign advance = item_valid && (!emit || !out_valid_reg || out_ready);

    // Next decoder state for the word in the input register.
    always_comb
    begin
        window_next = window_reg;
        shift_next  = {shift_reg[7:0], cls.bit_val};
        flags_next.short_seen = flags_reg.short_seen | cls.is_short;
        flags_next.long_seen  = flags_reg.long_seen  | cls.is_long;
        flags_next.amb_seen   = flags_reg.amb_seen   | cls.is_amb;
        pos_next    = pos_eff + POS_W'(1);
        idx_next    = idx_eff;
        if (pos_eff == POS_START)
        begin
            if (first_start)
            begin
                window_next = {item_time, 1'b0};
            end
            shift_next = '0;
            flags_next = '0;
            pos_next   = POS_FIRST_DATA;
        end
        else if (emit)
        begin
            pos_next = POS_START;
            idx_next = fin ? '0 : idx_plus[IDX_W-1:0];
        end
    end

    // Decoder state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= POS_START;
            idx_reg    <= '0;
            window_reg <= '0;
            shift_reg  <= '0;
            flags_reg  <= '0;
        end
        else if (advance)
        begin
            pos_reg    <= pos_next;
            idx_reg    <= idx_next;
            window_reg <= window_next;
            shift_reg  <= shift_next;
            flags_reg  <= flags_next;
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload, loaded when a byte completes.
    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            data_reg    <= shift_next[8:1];
            par_err_reg <= (^shift_next[8:1]) ^ shift_next[0];
            oflags_reg  <= flags_next;
            oidx_reg    <= idx_eff;
            last_reg    <= fin;
        end
    end

    assign out_valid      = out_valid_reg;
    assign data_byte      = data_reg;
    assign parity_error   = par_err_reg;
    assign short_seen     = oflags_reg.short_seen;
    assign long_seen      = oflags_reg.long_seen;
    assign ambiguous_seen = oflags_reg.amb_seen;
    assign byte_index     = oidx_reg;
    assign last           = last_reg;

endmodule

`default_nettype wire

// File: rtl/duty_cycle_serial_receiver_top.sv
// Top level of the duty-cycle serial receiver.
// Usage:
// The input channel (in_valid, in_ready) carries one word per pulse: the
// measured low time and a new_packet mark that forces a first start pulse.
// The first start pulse of a packet sets the bit window to twice its low time.
// Each byte takes ten words: start, eight data bits MSB first, even parity.
// The output channel (out_valid, out_ready) carries one word per byte.
// The configuration channel (cfg_valid, cfg_ready) writes the byte count;
// it is always ready and should be written only while the block is idle.
// A byte word is loaded into the result register when its parity pulse moves on
// from the input register, and out_valid stays high until out_ready takes it.
// Throughput: one pulse per cycle unless a byte waits in a stalled result
// register; classify and decode are combinational between the two registers.
// Reset clears the pulse count, window and flags, and sets the byte count to 3.
// When the receiver stalls, a finished byte waits in the result register;
// pulses that yield no byte keep flowing, and a pulse that ends the next
// byte waits in the input register, which then drops in_ready.
`default_nettype none

`include "duty_cycle_serial_receiver_top_macros.svh"

module duty_cycle_serial_receiver_top
    import dcsr_pkg::*;
#(
    parameter int TIME_BITS = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [TIME_BITS-1:0] low_time,
    input  wire logic                 new_packet,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CNT_W-1:0]     bytes_per_packet,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [7:0]                data_byte,
    output logic                      parity_error,
    output logic                      short_seen,
    output logic                      long_seen,
    output logic                      ambiguous_seen,
    output logic [IDX_W-1:0]          byte_index,
    output logic                      last
);

    logic                 s1_valid_reg;
    logic [TIME_BITS-1:0] s1_time_reg;
    logic                 s1_np_reg;
    logic [CNT_W-1:0]     bytes_reg;
    logic                 advance;

    assign cfg_ready = 1'b1;
    assign in_ready  = !s1_valid_reg || advance;

    // Byte count register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_reg <= BYTES_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            bytes_reg <= bytes_per_packet;
        end
    end

    // Input register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_time_reg <= low_time;
            s1_np_reg   <= new_packet;
        end
    end

    dcsr_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (s1_valid_reg),
        .item_time       (s1_time_reg),
        .item_new_packet (s1_np_reg),
        .bytes_cfg       (bytes_reg),
        .advance         (advance),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .data_byte       (data_byte),
        .parity_error    (parity_error),
        .short_seen      (short_seen),
        .long_seen       (long_seen),
        .ambiguous_seen  (ambiguous_seen),
        .byte_index      (byte_index),
        .last            (last)
    );

    // The input side stalls only behind a full, stalled result register.
    `DCSR_ASSERT_IMPL(a_stall_cause, clk, rst_n, !in_ready, s1_valid_reg && out_valid && !out_ready)
    // An empty result register never holds back the input.
    `DCSR_ASSERT_IMPL(a_empty_ready, clk, rst_n, !out_valid, in_ready)
    // A packet never holds more than three bytes.
    `DCSR_ASSERT_IMPL(a_idx_range, clk, rst_n, out_valid, byte_index != IDX_INVALID)
    // A stalled word in the input register stays there.
    `DCSR_ASSERT_NEXT(a_hold_word, clk, rst_n, !in_ready, s1_valid_reg)

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the duty-cycle serial receiver top level.
`timescale 1ns / 1ps

module testbench;
    import dcsr_pkg::*;

    localparam int PHASES = 12;
    localparam int PHASE_PULSES = 100;
    localparam int HOLD_PHASE = 2;
    localparam int HOLD_CYCLES = 150;
    localparam int SETTLE_CYCLES = 6;
    localparam int STALL_LIMIT = 2000;
    localparam int REPORT_MAX = 10;

    // Timing class that a generated pulse is meant to fall in.
    typedef enum int {
        KIND_SHORT,
        KIND_ONE,
        KIND_AMB,
        KIND_ZERO,
        KIND_LONG
    } pulse_kind_t;

    // One pulse word as offered on the input channel.
    typedef struct {
        logic [15:0] ticks;
        logic        restart;
    } pulse_word_t;

    // One received byte word as seen on the output channel.
    typedef struct packed {
        logic [7:0]       value;
        logic             parity_bad;
        logic             too_short;
        logic             too_long;
        logic             unclear;
        logic [IDX_W-1:0] position;
        logic             final_byte;
    } rx_byte_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic [15:0]      low_time = '0;
    logic             new_packet = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CNT_W-1:0] bytes_per_packet = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [7:0]       data_byte;
    logic             parity_error;
    logic             short_seen;
    logic             long_seen;
    logic             ambiguous_seen;
    logic [IDX_W-1:0] byte_index;
    logic             last;

    // Decoder state mirrored by the testbench.
    logic [CNT_W-1:0] byte_count = BYTES_RESET;
    int unsigned      slot_cnt = 0;
    logic [16:0]      win_ticks = '0;
    logic [8:0]       shift_reg = '0;
    class_flags_t     seen = '0;

    pulse_word_t pulse_q[$];
    rx_byte_t    byte_q[$];

    logic        pulse_taken = 1'b0;
    logic        byte_taken = 1'b0;
    logic [1:0]  send_gap = '0;
    logic [1:0]  recv_gap = '0;
    logic        send_gaps_on = 1'b1;
    logic        recv_gaps_on = 1'b1;
    logic        hold_request = 1'b0;
    logic        hold_used = 1'b0;
    logic        hold_off = 1'b0;
    int unsigned hold_left = 0;
    int unsigned stuck_cycles = 0;
    int unsigned error_cnt = 0;

    duty_cycle_serial_receiver_top dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .low_time         (low_time),
        .new_packet       (new_packet),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .bytes_per_packet (bytes_per_packet),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .data_byte        (data_byte),
        .parity_error     (parity_error),
        .short_seen       (short_seen),
        .long_seen        (long_seen),
        .ambiguous_seen   (ambiguous_seen),
        .byte_index       (byte_index),
        .last             (last)
    );

    always #5 clk = ~clk;

    // Counts an error and reports only the first few.
    function automatic void flag_error(input string what);
        error_cnt++;
        if (error_cnt <= REPORT_MAX)
            $display("%0t: %s", $time, what);
    endfunction

    // Advances the decoder by one pulse; returns 1 when a byte word is due.
    function automatic bit decode_pulse(input logic [15:0] t, input logic restart,
                                        output rx_byte_t res);
        int unsigned n, pos, idx, tt, ww;
        logic        b;
        logic        fin;
        n = (byte_count == 0) ? 1 : byte_count;
        res = '0;
        if (restart)
            slot_cnt = 0;
        pos = slot_cnt % 10;
        idx = slot_cnt / 10;

        // Start pulses clear the byte; only the first one sets the window.
        if (pos == POS_START) begin
            if (slot_cnt == 0)
                win_ticks = {t, 1'b0};
            shift_reg = '0;
            seen = '0;
            slot_cnt++;
            return 1'b0;
        end

        // Exact rational compares against the window.
        tt = 32'(t);
        ww = 32'(win_ticks);
        b = 1'b0;
        if (tt * PCT_SCALE <= ww * PCT_SHORT)
            seen.short_seen = 1'b1;
        else if (tt * PCT_SCALE <= ww * PCT_ONE)
            b = 1'b1;
        else if (tt * PCT_SCALE <= ww * PCT_AMB)
            seen.amb_seen = 1'b1;
        else if (tt > ww)
            seen.long_seen = 1'b1;
        shift_reg = {shift_reg[7:0], b};

        if (pos != POS_PARITY) begin
            slot_cnt++;
            return 1'b0;
        end

        fin = (idx + 1 >= n);
        res.value = shift_reg[8:1];
        res.parity_bad = (^shift_reg[8:1]) != shift_reg[0];
        res.too_short = seen.short_seen;
        res.too_long = seen.long_seen;
        res.unclear = seen.amb_seen;
        res.position = idx[IDX_W-1:0];
        res.final_byte = fin;
        slot_cnt = fin ? 0 : slot_cnt + 1;
        return 1'b1;
    endfunction

    // Picks a low time in the given class for window win, boundaries often.
    function automatic logic [15:0] pulse_ticks(input pulse_kind_t kind,
                                                input int unsigned win);
        int unsigned lo, hi;
        case (kind)
            KIND_SHORT: begin
                lo = 0;
                hi = win * PCT_SHORT / PCT_SCALE;
            end
            KIND_ONE: begin
                lo = win * PCT_SHORT / PCT_SCALE + 1;
                hi = win * PCT_ONE / PCT_SCALE;
            end
            KIND_AMB: begin
                lo = win * PCT_ONE / PCT_SCALE + 1;
                hi = win * PCT_AMB / PCT_SCALE;
            end
            KIND_ZERO: begin
                lo = win * PCT_AMB / PCT_SCALE + 1;
                hi = win;
            end
            default: begin
                lo = win + 1;
                hi = 65535;
            end
        endcase
        if (hi > 65535)
            hi = 65535;
        if (lo > hi)
            return 16'($urandom_range(0, 65535));
        case ($urandom_range(0, 3))
            0: return 16'(lo);
            1: return 16'(hi);
            default: return 16'($urandom_range(lo, hi));
        endcase
    endfunction

    function automatic void push_pulse(input logic [15:0] ticks, input logic restart);
        pulse_word_t w;
        w.ticks = ticks;
        w.restart = restart;
        pulse_q.push_back(w);
    endfunction

    // Queues one packet; a noisy packet may carry odd classes and bad parity.
    function automatic void queue_packet(input int nbytes, input bit clean);
        logic [15:0] first;
        int unsigned win;
        logic [7:0]  data;
        logic        par;
        logic        bit_val;
        pulse_kind_t kind;
        case ($urandom_range(0, 9))
            0: first = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(0, 3));
            1: first = 16'($urandom_range(0, 65535));
            default: first = 16'($urandom_range(20, 2000));
        endcase
        win = 2 * first;
        push_pulse(first, $urandom_range(0, 3) != 0);
        for (int b = 0; b < nbytes; b++) begin
            if (b != 0)
                push_pulse(16'($urandom_range(0, 65535)), 1'b0);
            data = 8'($urandom);
            par = ^data;
            if (!clean && $urandom_range(0, 9) == 0)
                par = ~par;
            for (int i = 0; i < 9; i++) begin
                bit_val = (i < 8) ? data[7 - i] : par;
                kind = bit_val ? KIND_ONE : KIND_ZERO;
                if (!clean && $urandom_range(0, 9) == 0)
                    kind = pulse_kind_t'($urandom_range(0, 4));
                push_pulse(pulse_ticks(kind, win), 1'b0);
            end
        end
    endfunction

    // Writes the byte count while the block is idle.
    task automatic write_byte_count(input logic [CNT_W-1:0] count);
        @(negedge clk);
        cfg_valid <= 1'b1;
        bytes_per_packet <= count;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        byte_count = count;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Waits until every pulse is taken and every expected byte has arrived.
    task automatic drain_block();
        @(negedge clk);
        while (pulse_q.size() != 0 || in_valid || byte_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Pulse driver: offers queued words with random gaps between them.
    always @(negedge clk) begin : pulse_driver
        pulse_word_t w;
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_gap <= '0;
        end else if (!in_valid || pulse_taken) begin
            if (send_gap != 0) begin
                send_gap <= send_gap - 1'b1;
                in_valid <= 1'b0;
            end else if (pulse_q.size() != 0) begin
                w = pulse_q.pop_front();
                in_valid <= 1'b1;
                low_time <= w.ticks;
                new_packet <= w.restart;
                send_gap <= send_gaps_on ? 2'($urandom_range(0, 3)) : 2'd0;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Byte receiver: drops ready for a random number of cycles after each word.
    always @(negedge clk) begin : byte_receiver
        logic [1:0] g;
        if (!rst_n) begin
            out_ready <= 1'b0;
            recv_gap <= '0;
        end else if (hold_off) begin
            out_ready <= 1'b0;
        end else if (byte_taken) begin
            g = recv_gaps_on ? 2'($urandom_range(0, 3)) : 2'd0;
            recv_gap <= g;
            out_ready <= (g == 0);
        end else if (recv_gap != 0) begin
            recv_gap <= recv_gap - 1'b1;
            out_ready <= (recv_gap == 1);
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Long receiver hold-off so that the block backs up into its input.
    always @(negedge clk) begin
        if (!rst_n) begin
            hold_left <= 0;
            hold_off <= 1'b0;
            hold_used <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            hold_off <= (hold_left > 1);
        end else if (hold_request && !hold_used) begin
            hold_used <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_off <= 1'b1;
        end
    end

    // Monitor: predicts on each taken pulse and checks each taken byte word.
    always @(posedge clk) begin : byte_monitor
        rx_byte_t want;
        rx_byte_t got;
        if (!rst_n) begin
            pulse_taken <= 1'b0;
            byte_taken <= 1'b0;
        end else begin
            pulse_taken <= in_valid && in_ready;
            byte_taken <= out_valid && out_ready;
            if (in_valid && in_ready) begin
                if (decode_pulse(low_time, new_packet, want))
                    byte_q.push_back(want);
            end
            if (out_valid && out_ready) begin
                got = {data_byte, parity_error, short_seen, long_seen, ambiguous_seen,
                       byte_index, last};
                if (byte_q.size() == 0) begin
                    flag_error($sformatf("unexpected byte word %02h", data_byte));
                end else begin
                    want = byte_q.pop_front();
                    if (got.value !== want.value || got.parity_bad !== want.parity_bad
                        || got.too_short !== want.too_short
                        || got.too_long !== want.too_long
                        || got.unclear !== want.unclear
                        || got.position !== want.position
                        || got.final_byte !== want.final_byte)
                        flag_error($sformatf({"byte mismatch: expected data %02h par %b ",
                            "short %b long %b amb %b idx %0d last %b, got data %02h ",
                            "par %b short %b long %b amb %b idx %0d last %b"},
                            want.value, want.parity_bad, want.too_short, want.too_long,
                            want.unclear, want.position, want.final_byte,
                            got.value, got.parity_bad, got.too_short, got.too_long,
                            got.unclear, got.position, got.final_byte));
                end
            end
        end
    end

    // Watchdog on cycles in which no word moves on any channel.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STALL_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // Stimulus: directed pulses, then phases under different byte counts.
    initial begin : stimulus
        int unsigned pick;
        int          eff;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Window of 100: every class boundary, with the reset byte count.
        push_pulse(16'd50, 1'b1);
        push_pulse(16'd11, 1'b0);
        push_pulse(16'd12, 1'b0);
        push_pulse(16'd36, 1'b0);
        push_pulse(16'd37, 1'b0);
        push_pulse(16'd61, 1'b0);
        push_pulse(16'd62, 1'b0);
        push_pulse(16'd100, 1'b0);
        push_pulse(16'd101, 1'b0);
        push_pulse(16'd0, 1'b0);
        // Zero window: zero is too short, anything else too long.
        push_pulse(16'd0, 1'b1);
        push_pulse(16'd0, 1'b0);
        push_pulse(16'hFFFF, 1'b0);
        push_pulse(16'd1, 1'b0);
        push_pulse(16'hFFFF, 1'b0);
        push_pulse(16'd0, 1'b0);
        push_pulse(16'd1, 1'b0);
        push_pulse(16'd0, 1'b0);
        push_pulse(16'd0, 1'b0);
        push_pulse(16'd0, 1'b0);
        // Largest window, left unfinished so the next phase breaks in.
        push_pulse(16'hFFFF, 1'b1);
        push_pulse(16'hFFFF, 1'b0);
        push_pulse(16'd14417, 1'b0);
        push_pulse(16'd14418, 1'b0);
        push_pulse(16'd47185, 1'b0);
        drain_block();

        for (int ph = 0; ph < PHASES; ph++) begin
            write_byte_count(CNT_W'((ph * 3 + 1) % 4));
            send_gaps_on = ($urandom_range(0, 3) != 0);
            recv_gaps_on = ($urandom_range(0, 3) != 0);
            if (ph == HOLD_PHASE)
                hold_request = 1'b1;
            eff = (byte_count == 0) ? 1 : byte_count;
            @(posedge clk);
            while (pulse_q.size() < PHASE_PULSES) begin
                pick = $urandom_range(0, 19);
                if (pick < 15) begin
                    queue_packet(eff, pick < 12);
                end else if (pick < 17) begin
                    queue_packet($urandom_range(1, 3), 1'b0);
                end else if (pick < 19) begin
                    // Packet broken off part way.
                    queue_packet($urandom_range(1, 3), 1'b0);
                    repeat ($urandom_range(1, 9))
                        pulse_q.delete(pulse_q.size() - 1);
                end else begin
                    repeat ($urandom_range(1, 5))
                        push_pulse(16'($urandom_range(0, 65535)),
                                   $urandom_range(0, 3) == 0);
                end
            end
            drain_block();
        end

        if (byte_q.size() != 0)
            flag_error($sformatf("%0d byte words never arrived", byte_q.size()));
        if (error_cnt == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/dcsr_pkg.sv
rtl/dcsr_classify.sv
rtl/dcsr_core.sv
rtl/duty_cycle_serial_receiver_top.sv
tb/testbench.sv
